// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TICKS = 2'd1;

    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd2000;
    localparam logic [7:0]  PHASE_TICKS_RST = 8'd1;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_WACK  = 3'd4;
    localparam logic [2:0] FUNC_READ  = 3'd5;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_ST_C    = 5'd3,
        PH_SP_A    = 5'd4,
        PH_SP_B    = 5'd5,
        PH_WR_PRE  = 5'd6,
        PH_WR_BIT  = 5'd7,
        PH_WR_HIGH = 5'd8,
        PH_WA_REL  = 5'd9,
        PH_WA_HIGH = 5'd10,
        PH_WA_POLL = 5'd11,
        PH_WA_LOW  = 5'd12,
        PH_RD_LOW  = 5'd13,
        PH_RD_HIGH = 5'd14,
        PH_RD_HOLD = 5'd15,
        PH_AK_A    = 5'd16,
        PH_AK_B    = 5'd17,
        PH_AK_C    = 5'd18,
        PH_AK_D    = 5'd19,
        PH_AK_E    = 5'd20
    } phase_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
        logic       timed_out;
    } out_item_t;

    typedef struct packed {
        logic      load;
        out_item_t result;
    } step_res_t;

endpackage

// ===== src/i2cm_core.sv =====
// Bus phase sequencer: state registers and the per-transaction step logic.
`timescale 1ns / 1ps

module i2cm_core
    import i2cm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   step_en,
    input  in_item_t               item,
    output step_res_t              step_res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  timer_reg, timer_next;
    logic [15:0] wait_cnt_reg, wait_cnt_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_choice_reg, ack_choice_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic        ack_flag_reg, ack_flag_next;
    logic        timeout_reg, timeout_next;
    logic [15:0] ack_timeout_reg;
    logic [7:0]  phase_ticks_reg;

    logic        done;
    logic        enter_en;
    phase_t      enter_ph;
    logic [3:0]  bit_inc;
    logic [7:0]  plen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                CFG_PHASE_TICKS: phase_ticks_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            timer_reg      <= '0;
            wait_cnt_reg   <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            rx_hold_reg    <= '0;
            ack_flag_reg   <= 1'b0;
            timeout_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            timer_reg      <= timer_next;
            wait_cnt_reg   <= wait_cnt_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_choice_reg <= ack_choice_next;
            rx_hold_reg    <= rx_hold_next;
            ack_flag_reg   <= ack_flag_next;
            timeout_reg    <= timeout_next;
        end
    end

    assign plen    = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign bit_inc = bit_cnt_reg + 4'd1;

    always_comb begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        timer_next      = timer_reg;
        wait_cnt_next   = wait_cnt_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        rx_hold_next    = rx_hold_reg;
        ack_flag_next   = ack_flag_reg;
        timeout_next    = timeout_reg;
        done            = 1'b0;
        enter_en        = 1'b0;
        enter_ph        = PH_IDLE;

        if (phase_reg == PH_IDLE) begin
            // commands are only taken while idle; other codes act as a tick
            case (item.func)
                FUNC_START: begin
                    enter_en = 1'b1;
                    enter_ph = PH_ST_A;
                end
                FUNC_STOP: begin
                    enter_en = 1'b1;
                    enter_ph = PH_SP_A;
                end
                FUNC_WRITE: begin
                    shift_next   = item.tx_byte;
                    bit_cnt_next = '0;
                    enter_en     = 1'b1;
                    enter_ph     = PH_WR_PRE;
                end
                FUNC_WACK: begin
                    ack_flag_next = 1'b0;
                    timeout_next  = 1'b0;
                    wait_cnt_next = '0;
                    enter_en      = 1'b1;
                    enter_ph      = PH_WA_REL;
                end
                FUNC_READ: begin
                    shift_next      = '0;
                    bit_cnt_next    = '0;
                    ack_choice_next = item.send_ack;
                    enter_en        = 1'b1;
                    enter_ph        = PH_RD_LOW;
                end
                default: ;
            endcase
        end else if (phase_reg == PH_WA_POLL) begin
            if (!item.sda_in) begin
                ack_flag_next = 1'b1;
                enter_en      = 1'b1;
                enter_ph      = PH_WA_LOW;
            end else if (wait_cnt_reg >= ack_timeout_reg) begin
                ack_flag_next = 1'b0;
                timeout_next  = 1'b1;
                enter_en      = 1'b1;
                enter_ph      = PH_SP_A;
            end else begin
                wait_cnt_next = wait_cnt_reg + 16'd1;
            end
        end else if (timer_reg > 8'd1) begin
            timer_next = timer_reg - 8'd1;
        end else begin
            unique case (phase_reg)
                PH_ST_A:    begin enter_en = 1'b1; enter_ph = PH_ST_B;    end
                PH_ST_B:    begin enter_en = 1'b1; enter_ph = PH_ST_C;    end
                PH_SP_A:    begin enter_en = 1'b1; enter_ph = PH_SP_B;    end
                PH_WR_PRE:  begin enter_en = 1'b1; enter_ph = PH_WR_BIT;  end
                PH_WR_BIT:  begin enter_en = 1'b1; enter_ph = PH_WR_HIGH; end
                PH_WR_HIGH: begin
                    scl_next     = 1'b0;
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_inc;
                    if (bit_inc >= 4'd8) begin
                        // last bit: release SDA for the slave's ack
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        done       = 1'b1;
                    end else begin
                        enter_en = 1'b1;
                        enter_ph = PH_WR_BIT;
                    end
                end
                PH_WA_REL:  begin enter_en = 1'b1; enter_ph = PH_WA_HIGH; end
                PH_WA_HIGH: begin enter_en = 1'b1; enter_ph = PH_WA_POLL; end
                PH_RD_LOW:  begin enter_en = 1'b1; enter_ph = PH_RD_HIGH; end
                PH_RD_HIGH: begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                    enter_en   = 1'b1;
                    enter_ph   = PH_RD_HOLD;
                end
                PH_RD_HOLD: begin
                    bit_cnt_next = bit_inc;
                    enter_en     = 1'b1;
                    if (bit_inc >= 4'd8) begin
                        rx_hold_next = shift_reg;
                        enter_ph     = PH_AK_A;
                    end else begin
                        enter_ph = PH_RD_LOW;
                    end
                end
                PH_AK_A: begin enter_en = 1'b1; enter_ph = PH_AK_B; end
                PH_AK_B: begin enter_en = 1'b1; enter_ph = PH_AK_C; end
                PH_AK_C: begin enter_en = 1'b1; enter_ph = PH_AK_D; end
                PH_AK_D: begin
                    if (ack_choice_reg) begin
                        enter_en = 1'b1;
                        enter_ph = PH_AK_E;
                    end else begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        done       = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    done       = 1'b1;
                end
            endcase
        end

        // entry actions of the new phase
        if (enter_en) begin
            phase_next = enter_ph;
            timer_next = plen;
            unique case (enter_ph)
                PH_ST_A:    begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_ST_B:    sda_next = 1'b0;
                PH_ST_C:    scl_next = 1'b0;
                PH_SP_A:    begin sda_next = 1'b0; scl_next = 1'b1; end
                PH_SP_B:    sda_next = 1'b1;
                PH_WR_PRE:  scl_next = 1'b0;
                PH_WR_BIT:  begin scl_next = 1'b0; sda_next = shift_next[7]; end
                PH_WR_HIGH: scl_next = 1'b1;
                PH_WA_REL:  sda_next = 1'b1;
                PH_WA_HIGH: scl_next = 1'b1;
                PH_WA_POLL: timer_next = '0;
                PH_WA_LOW:  scl_next = 1'b0;
                PH_RD_LOW:  begin scl_next = 1'b0; sda_next = 1'b1; end
                PH_RD_HIGH: scl_next = 1'b1;
                PH_AK_A:    scl_next = 1'b0;
                PH_AK_B:    sda_next = !ack_choice_next;
                PH_AK_C:    scl_next = 1'b1;
                PH_AK_D:    scl_next = 1'b0;
                PH_AK_E:    sda_next = 1'b1;
                default: ;
            endcase
        end
    end

    assign step_res.load                = step_en;
    assign step_res.result.scl_level    = scl_next;
    assign step_res.result.sda_level    = sda_next;
    assign step_res.result.busy_res     = (phase_next != PH_IDLE);
    assign step_res.result.done_res     = done;
    assign step_res.result.rx_byte      = rx_hold_next;
    assign step_res.result.ack_received = ack_flag_next;
    assign step_res.result.timed_out    = timeout_next;

endmodule

// ===== src/i2cm_out_stage.sv =====
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module i2cm_out_stage
    import i2cm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  step_res_t step_res,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      valid_reg;
    out_item_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step_res.load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_res.load) begin
            data_reg <= step_res.result;
        end
    end

    // a new result may replace the held one in the cycle it is taken
    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

endmodule

// ===== src/i2c_master_bit_engine.sv =====
// The result of a transaction is registered and shows on m_* in the cycle after it.
// Throughput: one transaction per cycle unless a held result stalls on m_ready low; the
// output register lets s_ready stay high while a held result is taken in the same cycle.
// Each phase but the ack poll lasts phase_ticks transactions (0 as 1), by the phase timer.
// Reset (aresetn low, synchronous): idle, SCL and SDA released, registers to defaults.
`timescale 1ns / 1ps

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    step_res_t step_res;
    logic      can_load;

    assign s_ready = can_load;

    i2cm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (s_valid && can_load),
        .item      (s_data),
        .step_res  (step_res)
    );

    i2cm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_res (step_res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== src/i2cm_checker.sv =====
// Port-level assertions for the I2C master bit engine, bound to the top level.
`timescale 1ns / 1ps

module i2cm_checker
    import i2cm_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input out_item_t              m_data
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transaction produced no result");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done while still busy");

    a_timeout_no_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.timed_out |-> !m_data.ack_received)
        else $error("timeout reported together with ack");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);
